FILE: rtl/bec_pkg.sv
package bec_pkg;

   localparam int NUM_BUTTONS_DEF   = 8;
   localparam int HISTORY_DEPTH_DEF = 32;

   localparam int REQ_W       = 2;
   localparam int TIME_W      = 16;
   localparam int KEYS_W      = 8;
   localparam int QCTL_W      = 4;
   localparam int ACT_W       = 3;
   localparam int HELD_W      = 24;
   localparam int KIND_W      = 2;
   localparam int OCTL_W      = 3;
   localparam int TMR_W       = 18;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int MAX_RESULTS = 16;
   localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

   localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
   localparam logic [REQ_W-1:0] REQ_QCUR = 2'd1;
   localparam logic [REQ_W-1:0] REQ_QBUF = 2'd2;

   localparam logic [KIND_W-1:0] KIND_EVENT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ANSWER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

   localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_PRESS   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_HOLD    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DOUBLE  = 3'd4;
   localparam logic [ACT_W-1:0] QACT_ANY    = 3'd0;

   localparam logic [QCTL_W-1:0] CTL_NONE = 4'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_LIFE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd1;

   localparam logic [TIME_W-1:0] LIFE_RST   = 16'd512;
   localparam logic [TIME_W-1:0] WINDOW_RST = 16'd256;
   localparam logic [HELD_W-1:0] HELD_MAX   = 24'hFFFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_EMPTY,
      ST_ANSWER,
      ST_SCAN_RD,
      ST_SCAN_CMP
   } state_type;

   typedef struct packed {
      logic tick_start;
      logic tick_step;
      logic query_cur;
      logic scan_start;
      logic scan_read;
      logic scan_cmp;
      logic emit_answer;
      logic emit_empty;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic slot_active;
      logic slot_last;
      logic emit_ok;
      logic no_events;
      logic scan_end;
   } stat_type;

   function automatic logic ev_match(
      input logic [QCTL_W-1:0] ctl,
      input logic [ACT_W-1:0]  act,
      input logic [HELD_W-1:0] held,
      input logic [QCTL_W-1:0] qc,
      input logic [ACT_W-1:0]  qa,
      input logic              anyh,
      input logic [HELD_W-1:0] minh
   );
      return (qc == ctl) && (qa == QACT_ANY || qa == act) && (anyh || minh <= held);
   endfunction

endpackage

FILE: rtl/bec_ctrl.sv
module bec_ctrl
   import bec_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [REQ_W-1:0] req_type,
   input  stat_type         stat,
   output logic             req_ready,
   output cmd_type          cmd
);

   state_type state_ff, state_in;
   logic      tick_stall;

   assign tick_stall = stat.slot_active && stat.emit_ok && !stat.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_type)
                  REQ_TICK: state_in = ST_TICK;
                  REQ_QCUR: state_in = ST_ANSWER;
                  REQ_QBUF: state_in = ST_SCAN_RD;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_TICK: begin
            if (!tick_stall && stat.slot_last) begin
               state_in = stat.no_events ? ST_EMPTY : ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         ST_ANSWER: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         ST_SCAN_RD: begin
            state_in = stat.scan_end ? ST_ANSWER : ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            state_in = ST_SCAN_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      cmd             = '0;
      cmd.tick_start  = (state_ff == ST_IDLE) && req_valid && (req_type == REQ_TICK);
      cmd.query_cur   = (state_ff == ST_IDLE) && req_valid && (req_type == REQ_QCUR);
      cmd.scan_start  = (state_ff == ST_IDLE) && req_valid && (req_type == REQ_QBUF);
      cmd.tick_step   = (state_ff == ST_TICK) && !tick_stall;
      cmd.emit_empty  = (state_ff == ST_EMPTY) && stat.out_free;
      cmd.emit_answer = (state_ff == ST_ANSWER) && stat.out_free;
      cmd.scan_read   = (state_ff == ST_SCAN_RD) && !stat.scan_end;
      cmd.scan_cmp    = (state_ff == ST_SCAN_CMP);
   end

endmodule

FILE: rtl/bec_datapath.sv
module bec_datapath
   import bec_pkg::*;
#(
   parameter int NUM_BUTTONS   = NUM_BUTTONS_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [TIME_W-1:0]     req_tick_time,
   input  logic [KEYS_W-1:0]     req_keys_down,
   input  logic [QCTL_W-1:0]     req_query_control,
   input  logic [ACT_W-1:0]      req_query_action,
   input  logic                  req_any_held,
   input  logic [HELD_W-1:0]     req_min_held,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [KIND_W-1:0]     rsp_result_kind,
   output logic [OCTL_W-1:0]     rsp_event_control,
   output logic [ACT_W-1:0]      rsp_event_action,
   output logic [HELD_W-1:0]     rsp_event_held,
   output logic                  rsp_match,
   output logic                  rsp_buffer_dropped,
   output logic                  rsp_last
);

   localparam int BTN_W  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int NSLOT  = 2 * NUM_BUTTONS;
   localparam int SLOT_W = BTN_W + 1;
   localparam int AW     = $clog2(HISTORY_DEPTH);
   localparam int CW     = AW + 1;
   localparam int ENT_W  = BTN_W + ACT_W + HELD_W;

   logic [TIME_W-1:0]       life_ff, window_ff;
   logic [ACT_W-1:0]        act_ff  [NUM_BUTTONS];
   logic                    dbl_ff  [NUM_BUTTONS];
   logic [HELD_W-1:0]       held_ff [NUM_BUTTONS];
   logic [ACT_W-1:0]        act_in  [NUM_BUTTONS];
   logic                    dbl_in  [NUM_BUTTONS];
   logic [HELD_W-1:0]       held_in [NUM_BUTTONS];
   logic [NSLOT-1:0]        mask_in, mask_ff;
   logic [CW-1:0]           count_ff, j_ff;
   logic signed [TMR_W-1:0] timer_ff;
   logic                    last_valid_ff;
   logic [BTN_W-1:0]        last_ctl_ff;
   logic [ACT_W-1:0]        last_act_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic [NRES_W-1:0]       n_ff;
   logic [QCTL_W-1:0]       qctl_ff;
   logic [ACT_W-1:0]        qact_ff;
   logic                    qany_ff;
   logic [HELD_W-1:0]       qmin_ff;
   logic                    match_ff;
   logic [ENT_W-1:0]        mem [HISTORY_DEPTH];
   logic [ENT_W-1:0]        rd_ff;
   logic                    rsp_valid_ff;

   logic [NUM_BUTTONS+KEYS_W-1:0] keys_ext;
   logic signed [TMR_W-1:0] age, tmr_dec;
   logic                    in_window;
   logic [BTN_W-1:0]        sbtn;
   logic [ACT_W-1:0]        sact;
   logic [HELD_W-1:0]       sheld;
   logic [NSLOT-1:0]        rest;
   logic                    more_after, full, step_emit, wr_en;
   logic [BTN_W-1:0]        qi;
   logic                    q_inrange, cur_match, scan_hit;

   assign keys_ext  = {{NUM_BUTTONS{1'b0}}, req_keys_down};
   assign age       = $signed({2'b00, life_ff}) - timer_ff;
   assign in_window = age < $signed({2'b00, window_ff});
   assign tmr_dec   = timer_ff - $signed({2'b00, req_tick_time});

   always_comb begin
      logic                down, was, rel_before;
      logic [HELD_W:0]     sum;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         down       = keys_ext[i];
         was        = (act_ff[i] != ACT_NONE) && (act_ff[i] != ACT_RELEASE);
         sum        = {1'b0, held_ff[i]} + {{(HELD_W+1-TIME_W){1'b0}}, req_tick_time};
         rel_before = last_valid_ff && (last_ctl_ff == BTN_W'(i)) &&
                      (last_act_ff == ACT_RELEASE);
         act_in[i]  = ACT_NONE;
         dbl_in[i]  = 1'b0;
         if (down && was) begin
            act_in[i] = ACT_HOLD;
         end else if (!down && was) begin
            act_in[i] = ACT_RELEASE;
         end else if (down) begin
            act_in[i] = ACT_PRESS;
            dbl_in[i] = rel_before && in_window;
         end
         held_in[i]       = (act_in[i] == ACT_NONE) ? '0 :
                            (sum[HELD_W] ? HELD_MAX : sum[HELD_W-1:0]);
         mask_in[2*i]     = (act_in[i] != ACT_NONE);
         mask_in[2*i + 1] = dbl_in[i];
      end
   end

   assign sbtn       = slot_ff[SLOT_W-1:1];
   assign sact       = slot_ff[0] ? ACT_DOUBLE : act_ff[sbtn];
   assign sheld      = held_ff[sbtn];
   assign rest       = mask_ff >> slot_ff;
   assign more_after = |rest[NSLOT-1:1];
   assign full       = (count_ff == CW'(HISTORY_DEPTH));
   assign step_emit  = cmd.tick_step && mask_ff[slot_ff] && (n_ff < NRES_W'(MAX_RESULTS));
   assign wr_en      = cmd.tick_step && mask_ff[slot_ff] && !full;

   assign qi        = req_query_control[BTN_W-1:0];
   assign q_inrange = ({1'b0, req_query_control} < (QCTL_W+1)'(NUM_BUTTONS));
   assign cur_match = (req_query_control == CTL_NONE) ||
      (q_inrange && act_ff[qi] != ACT_NONE &&
       (ev_match(req_query_control, act_ff[qi], held_ff[qi], req_query_control,
                 req_query_action, req_any_held, req_min_held) ||
        (dbl_ff[qi] &&
         ev_match(req_query_control, ACT_DOUBLE, held_ff[qi], req_query_control,
                  req_query_action, req_any_held, req_min_held))));
   assign scan_hit  = ev_match(QCTL_W'(rd_ff[ENT_W-1 -: BTN_W]),
                               rd_ff[HELD_W +: ACT_W], rd_ff[HELD_W-1:0],
                               qctl_ff, qact_ff, qany_ff, qmin_ff);

   always_comb begin
      stat             = '0;
      stat.out_free    = !rsp_valid_ff || rsp_ready;
      stat.slot_active = mask_ff[slot_ff];
      stat.slot_last   = (slot_ff == SLOT_W'(NSLOT - 1));
      stat.emit_ok     = (n_ff < NRES_W'(MAX_RESULTS));
      stat.no_events   = (mask_ff == '0);
      stat.scan_end    = match_ff || (j_ff >= count_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= {sbtn, sact, sheld};
      end
      if (cmd.scan_read) begin
         rd_ff <= mem[j_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         life_ff       <= LIFE_RST;
         window_ff     <= WINDOW_RST;
         count_ff      <= '0;
         timer_ff      <= $signed({2'b00, LIFE_RST});
         last_valid_ff <= 1'b0;
         last_ctl_ff   <= '0;
         last_act_ff   <= ACT_NONE;
         mask_ff       <= '0;
         slot_ff       <= '0;
         n_ff          <= '0;
         j_ff          <= '0;
         match_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            act_ff[i]  <= ACT_NONE;
            dbl_ff[i]  <= 1'b0;
            held_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_index == CSR_LIFE)   life_ff   <= csr_wdata;
         if (csr_valid && csr_index == CSR_WINDOW) window_ff <= csr_wdata;

         if (cmd.tick_start) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
               act_ff[i]  <= act_in[i];
               dbl_ff[i]  <= dbl_in[i];
               held_ff[i] <= held_in[i];
            end
            mask_ff <= mask_in;
            slot_ff <= '0;
            n_ff    <= '0;
            if (tmr_dec < 0) begin
               count_ff      <= '0;
               last_valid_ff <= 1'b0;
               timer_ff      <= $signed({2'b00, life_ff});
            end else begin
               timer_ff <= tmr_dec;
            end
         end

         if (cmd.tick_step) begin
            slot_ff <= slot_ff + SLOT_W'(1);
            if (mask_ff[slot_ff]) begin
               timer_ff <= $signed({2'b00, life_ff});
               if (!full) begin
                  count_ff      <= count_ff + CW'(1);
                  last_valid_ff <= 1'b1;
                  last_ctl_ff   <= sbtn;
                  last_act_ff   <= sact;
               end
            end
            if (step_emit) n_ff <= n_ff + NRES_W'(1);
         end

         if (cmd.query_cur) match_ff <= cur_match;
         if (cmd.scan_start) begin
            match_ff <= (req_query_control == CTL_NONE);
            j_ff     <= '0;
         end
         if (cmd.scan_cmp) begin
            match_ff <= match_ff | scan_hit;
            j_ff     <= j_ff + CW'(1);
         end

         if (step_emit || cmd.emit_answer || cmd.emit_empty) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         qctl_ff <= req_query_control;
         qact_ff <= req_query_action;
         qany_ff <= req_any_held;
         qmin_ff <= req_min_held;
      end
      if (step_emit) begin
         rsp_result_kind    <= KIND_EVENT;
         rsp_event_control  <= OCTL_W'(sbtn);
         rsp_event_action   <= sact;
         rsp_event_held     <= sheld;
         rsp_match          <= 1'b0;
         rsp_buffer_dropped <= full;
         rsp_last           <= !more_after || (n_ff == NRES_W'(MAX_RESULTS - 1));
      end else if (cmd.emit_answer || cmd.emit_empty) begin
         rsp_result_kind    <= cmd.emit_answer ? KIND_ANSWER : KIND_EMPTY;
         rsp_event_control  <= '0;
         rsp_event_action   <= ACT_NONE;
         rsp_event_held     <= '0;
         rsp_match          <= cmd.emit_answer && match_ff;
         rsp_buffer_dropped <= 1'b0;
         rsp_last           <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(HISTORY_DEPTH))
      else $error("history count beyond depth");

   a_timer_nonneg: assert property (@(posedge clock) disable iff (reset)
      !timer_ff[TMR_W-1])
      else $error("history timer negative");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (step_emit || cmd.emit_answer || cmd.emit_empty) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");

   a_store_resets_timer: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (timer_ff == $signed({2'b00, $past(life_ff)})))
      else $error("timer not reloaded on new event");
`endif

endmodule

FILE: rtl/button_event_classifier_top.sv
// Channel   Handshake              Payload
// req       req_valid/req_ready    req_type, tick_time, keys_down, query_*, any_held, min_held
// rsp       rsp_valid/rsp_ready    result_kind, event_*, match, buffer_dropped, last
// csr       csr_valid/csr_ready    csr_index, csr_wdata (ready always high)
//
// One request at a time. A tick walks 2*NUM_BUTTONS event slots, one a cycle unless a stalled
// rsp holds the walk; a tick that finds no events then gives one empty-tick result.
// A current-event query gives one answer; a buffered query reads stored entries one by one
// from the history memory port until a match or the end of the stored entries.
// Synchronous reset; no clearing pass. A stalled rsp holds the walk at the next emitting slot.
module button_event_classifier_top
   import bec_pkg::*;
#(
   parameter int NUM_BUTTONS   = NUM_BUTTONS_DEF,
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [REQ_W-1:0]      req_type,
   input  logic [TIME_W-1:0]     req_tick_time,
   input  logic [KEYS_W-1:0]     req_keys_down,
   input  logic [QCTL_W-1:0]     req_query_control,
   input  logic [ACT_W-1:0]      req_query_action,
   input  logic                  req_any_held,
   input  logic [HELD_W-1:0]     req_min_held,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [KIND_W-1:0]     rsp_result_kind,
   output logic [OCTL_W-1:0]     rsp_event_control,
   output logic [ACT_W-1:0]      rsp_event_action,
   output logic [HELD_W-1:0]     rsp_event_held,
   output logic                  rsp_match,
   output logic                  rsp_buffer_dropped,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   bec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   bec_datapath #(
      .NUM_BUTTONS   (NUM_BUTTONS),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_tick_time      (req_tick_time),
      .req_keys_down      (req_keys_down),
      .req_query_control  (req_query_control),
      .req_query_action   (req_query_action),
      .req_any_held       (req_any_held),
      .req_min_held       (req_min_held),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_event_control  (rsp_event_control),
      .rsp_event_action   (rsp_event_action),
      .rsp_event_held     (rsp_event_held),
      .rsp_match          (rsp_match),
      .rsp_buffer_dropped (rsp_buffer_dropped),
      .rsp_last           (rsp_last)
   );

endmodule
